// ----- src/gregorian_date_add_and_diff_core_assert.svh -----
// assertion macros for the gregorian date add and distance core
// expects clk and rst_n in the scope that includes this header
`ifndef GREGORIAN_DATE_ADD_AND_DIFF_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ADD_AND_DIFF_CORE_ASSERT_SVH

// condition holds in the same cycle
`define GDAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define GDAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gdad_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and calendar helper functions for the date add/distance core
// no dependencies
package gdad_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SER_W   = 22;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned OFF_W   = 17;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [MONTH_W-1:0] DEC       = 4'd12;
  localparam logic [DAY_W-1:0]   LAST_DAY  = 5'd31;

  // request action, carried alone in in_tuser
  typedef enum logic {
    ACT_ADD      = 1'b0,
    ACT_DISTANCE = 1'b1
  } action_t;

  // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 16384
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;

  // days in month m, 0 for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                 len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] cum;
    unique case (m)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

// ----- src/gregorian_date_add_and_diff_core.sv -----
`timescale 1ns / 1ps
// gregorian date unit: add a day count to a date, or day distance between two dates
// depends on gdad_pkg and gregorian_date_add_and_diff_core_assert.svh
//
//  channel   dir  handshake            payload
//  in_       in   in_tvalid/in_tready  in_tuser = action, in_tdata = dates and add count
//  out_      out  out_tvalid/out_tready out_tdata = result date, flags, distance
//
// add request: set-up states, then the month stepper, which crosses one month per step
//   with its single compare/subtract
// distance request: two passes of the year stages, for a then b, on the shared divide-by-100 multiplier
// in_tready is high only while the sequencer is idle; one request at a time
// a finished result waits in the output register; the sequencer holds in its
// done state until that register is free
// synchronous active-low reset clears the sequencer, sel_b_r and out_tvalid only
`include "gregorian_date_add_and_diff_core_assert.svh"

module gregorian_date_add_and_diff_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // action: 0 add days to a, 1 distance a to b
  input  logic [63:0] in_tdata,   // day_a, month_a, year_a, day_b, month_b, year_b, add_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // out_day, out_month, out_year, a_before_b,
                                  // day_distance, year_overflow, bad_date
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVY,    // year / 100
    S_MODY,    // year % 100, century % 4, (year-1) / 100
    S_YSTART,  // days up to 1 jan of the year
    S_SERIAL,  // serial day number, date check, branch
    S_STEP,    // month stepper for an add
    S_DONE
  } state_t;

  state_t state_r;

  // captured request
  logic                             act_r;
  logic [gdad_pkg::DAY_W-1:0]       da_r, db_r;
  logic [gdad_pkg::MONTH_W-1:0]     ma_r, mb_r;
  logic [gdad_pkg::YEAR_W-1:0]      ya_r, yb_r;
  logic [gdad_pkg::COUNT_W-1:0]     cnt_r;
  logic                             before_r;
  logic                             sel_b_r;

  // working registers
  logic [gdad_pkg::QUO_W-1:0]       q_r;
  logic [6:0]                       mod100_r;
  logic [1:0]                       cent4_r;
  logic [gdad_pkg::SER_W-1:0]       ys_r;
  logic [gdad_pkg::SER_W-1:0]       ser_a_r;
  logic [gdad_pkg::SER_W-1:0]       dist_r;
  logic [gdad_pkg::OFF_W-1:0]       off_r;
  logic [gdad_pkg::DAY_W-1:0]       day_r;
  logic [gdad_pkg::MONTH_W-1:0]     mon_r;
  logic [gdad_pkg::YEAR_W-1:0]      yr_r;
  logic                             ovf_r;
  logic                             bad_r;

  // output register
  logic                             out_valid_r;
  logic [gdad_pkg::DAY_W-1:0]       o_day_r;
  logic [gdad_pkg::MONTH_W-1:0]     o_month_r;
  logic [gdad_pkg::YEAR_W-1:0]      o_year_r;
  logic                             o_before_r;
  logic [gdad_pkg::SER_W-1:0]       o_dist_r;
  logic                             o_ovf_r;
  logic                             o_bad_r;

  // input field split
  logic [gdad_pkg::DAY_W-1:0]       in_da, in_db;
  logic [gdad_pkg::MONTH_W-1:0]     in_ma, in_mb;
  logic [gdad_pkg::YEAR_W-1:0]      in_ya, in_yb;
  logic [gdad_pkg::COUNT_W-1:0]     in_cnt;
  logic                             in_before;

  assign in_da  = in_tdata[4:0];
  assign in_ma  = in_tdata[8:5];
  assign in_ya  = in_tdata[22:9];
  assign in_db  = in_tdata[27:23];
  assign in_mb  = in_tdata[31:28];
  assign in_yb  = in_tdata[45:32];
  assign in_cnt = in_tdata[61:46];

  // field-by-field compare, b need not be a valid date
  assign in_before = (in_ya < in_yb) ||
                     ((in_ya == in_yb) && ((in_ma < in_mb) ||
                                           ((in_ma == in_mb) && (in_da < in_db))));

  // date currently being worked on
  logic [gdad_pkg::DAY_W-1:0]       cur_d;
  logic [gdad_pkg::MONTH_W-1:0]     cur_m;
  logic [gdad_pkg::YEAR_W-1:0]      cur_y;
  logic [gdad_pkg::YEAR_W-1:0]      cur_p;

  assign cur_d = sel_b_r ? db_r : da_r;
  assign cur_m = sel_b_r ? mb_r : ma_r;
  assign cur_y = sel_b_r ? yb_r : ya_r;
  assign cur_p = cur_y - 14'd1;

  // shared divide-by-100 unit: one constant multiply, result registered in q_r
  logic [gdad_pkg::YEAR_W-1:0]      mul_x;
  logic [26:0]                      mul_prod;
  logic [gdad_pkg::QUO_W-1:0]       quo100;

  assign mul_x    = (state_r == S_DIVY) ? cur_y : cur_p;
  assign mul_prod = {13'd0, mul_x} * {14'd0, gdad_pkg::DIV100_MUL};
  assign quo100   = mul_prod[26:gdad_pkg::DIV100_SHIFT];

  // year % 100 from the registered quotient
  logic [14:0]                      hund;
  logic [gdad_pkg::YEAR_W-1:0]      y_rem;

  assign hund  = {7'd0, q_r} * 15'd100;
  assign y_rem = cur_y - hund[13:0];

  // leap rule from low year bits and the kept residues
  logic [1:0] y_low;
  logic       leap;

  assign y_low = (state_r == S_STEP) ? yr_r[1:0] : cur_y[1:0];
  assign leap  = ((y_low == 2'd0) && (mod100_r != 7'd0)) ||
                 ((mod100_r == 7'd0) && (cent4_r == 2'd0));

  // days up to 1 jan: 365p + p/4 - p/100 + p/400, q_r holds p/100 here
  logic [gdad_pkg::SER_W-1:0] ystart;

  assign ystart = ({8'd0, cur_p} * 22'd365) + {10'd0, cur_p[13:2]} +
                  {16'd0, q_r[7:2]} - {14'd0, q_r};

  // serial day number and validity of the current date
  logic [gdad_pkg::DAY_W-1:0] cur_len;
  logic [gdad_pkg::SER_W-1:0] serial;
  logic                       date_ok;

  assign cur_len = gdad_pkg::month_len(cur_m, leap);
  assign serial  = ys_r + {13'd0, gdad_pkg::days_before(cur_m)} +
                   {21'd0, leap && (cur_m > 4'd2)} + {17'd0, cur_d} - 22'd1;
  assign date_ok = (cur_m >= 4'd1) && (cur_m <= gdad_pkg::DEC) &&
                   (cur_y >= 14'd1) && (cur_y <= gdad_pkg::MAX_YEAR) &&
                   (cur_d >= 5'd1) && (cur_d <= cur_len);

  // month stepper compare
  logic [gdad_pkg::DAY_W-1:0] step_len;
  logic                       step_fits;

  assign step_len  = gdad_pkg::month_len(mon_r, leap);
  assign step_fits = off_r < {12'd0, step_len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_b_r     <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            act_r    <= in_tuser;
            da_r     <= in_da;
            ma_r     <= in_ma;
            ya_r     <= in_ya;
            db_r     <= in_db;
            mb_r     <= in_mb;
            yb_r     <= in_yb;
            cnt_r    <= in_cnt;
            before_r <= in_before;
            sel_b_r  <= 1'b0;
            bad_r    <= 1'b0;
            ovf_r    <= 1'b0;
            state_r  <= S_DIVY;
          end
        end
        S_DIVY: begin
          q_r     <= quo100;
          state_r <= S_MODY;
        end
        S_MODY: begin
          mod100_r <= y_rem[6:0];
          cent4_r  <= q_r[1:0];
          q_r      <= quo100;
          state_r  <= S_YSTART;
        end
        S_YSTART: begin
          ys_r    <= ystart;
          state_r <= S_SERIAL;
        end
        S_SERIAL: begin
          if (!sel_b_r) begin
            ser_a_r <= serial;
            bad_r   <= !date_ok;
            if (act_r == gdad_pkg::ACT_ADD) begin
              off_r   <= {12'd0, da_r} - 17'd1 + {1'b0, cnt_r};
              mon_r   <= ma_r;
              yr_r    <= ya_r;
              state_r <= date_ok ? S_STEP : S_DONE;
            end else begin
              sel_b_r <= 1'b1;
              state_r <= S_DIVY;
            end
          end else begin
            bad_r   <= bad_r || !date_ok;
            dist_r  <= serial - ser_a_r;
            state_r <= S_DONE;
          end
        end
        S_STEP: begin
          priority if (step_fits) begin
            day_r   <= off_r[4:0] + 5'd1;
            state_r <= S_DONE;
          end else if (mon_r != gdad_pkg::DEC) begin
            off_r <= off_r - {12'd0, step_len};
            mon_r <= mon_r + 4'd1;
          end else if (yr_r == gdad_pkg::MAX_YEAR) begin
            // ran past the last representable day
            day_r   <= gdad_pkg::LAST_DAY;
            ovf_r   <= 1'b1;
            state_r <= S_DONE;
          end else begin
            off_r <= off_r - {12'd0, step_len};
            mon_r <= 4'd1;
            yr_r  <= yr_r + 14'd1;
            if (mod100_r == 7'd99) begin
              mod100_r <= 7'd0;
              cent4_r  <= cent4_r + 2'd1;
            end else begin
              mod100_r <= mod100_r + 7'd1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            o_bad_r     <= bad_r;
            if (bad_r) begin
              o_day_r    <= '0;
              o_month_r  <= '0;
              o_year_r   <= '0;
              o_before_r <= 1'b0;
              o_dist_r   <= '0;
              o_ovf_r    <= 1'b0;
            end else if (act_r == gdad_pkg::ACT_ADD) begin
              o_day_r    <= day_r;
              o_month_r  <= mon_r;
              o_year_r   <= yr_r;
              o_before_r <= before_r;
              o_dist_r   <= '0;
              o_ovf_r    <= ovf_r;
            end else begin
              o_day_r    <= '0;
              o_month_r  <= '0;
              o_year_r   <= '0;
              o_before_r <= before_r;
              o_dist_r   <= before_r ? dist_r : '0;
              o_ovf_r    <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_bad_r, o_ovf_r, o_dist_r, o_before_r, o_year_r, o_month_r, o_day_r};

  // a flagged bad date carries nothing else
  `GDAD_ASSERT_NOW(a_bad_clears, out_tvalid && out_tdata[47], out_tdata[46:0] == 47'd0, "bad date result carries data")
  // an overflow holds the date at the last day of year 9999
  `GDAD_ASSERT_NOW(a_ovf_date, out_tvalid && out_tdata[46], (out_tdata[4:0] == 5'd31) && (out_tdata[8:5] == 4'd12) && (out_tdata[22:9] == 14'd9999), "overflow date not held")
  // a distance is only given when a is before b
  `GDAD_ASSERT_NOW(a_dist_order, out_tvalid && (out_tdata[45:24] != 22'd0), out_tdata[23], "distance without a before b")
  // the month stepper only ever holds a real month
  `GDAD_ASSERT_NOW(a_step_month, state_r == S_STEP, (mon_r >= 4'd1) && (mon_r <= 4'd12), "month stepper out of range")
  // an accepted request starts the sequencer
  `GDAD_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, state_r == S_DIVY, "request accepted but sequencer not started")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for gregorian_date_add_and_diff_core: directed and random
// add and distance requests, with its own calendar arithmetic predicting each result
// depends on gdad_pkg and the core under src

module testbench;

  typedef logic [gdad_pkg::DAY_W-1:0]   day_t;
  typedef logic [gdad_pkg::MONTH_W-1:0] month_t;
  typedef logic [gdad_pkg::YEAR_W-1:0]  year_t;
  typedef logic [gdad_pkg::COUNT_W-1:0] count_t;
  typedef logic [gdad_pkg::SER_W-1:0]   dist_t;

  // in_tdata layout, lowest bits first: day_a, month_a, year_a, day_b, month_b,
  // year_b, add_count, then two bits of zero padding
  typedef struct packed {
    logic [1:0] pad;
    count_t     add_count;
    year_t      year_b;
    month_t     month_b;
    day_t       day_b;
    year_t      year_a;
    month_t     month_a;
    day_t       day_a;
  } date_fields_t;

  // out_tdata layout, lowest bits last
  typedef struct packed {
    logic   bad_date;
    logic   year_overflow;
    dist_t  day_distance;
    logic   a_before_b;
    year_t  out_year;
    month_t out_month;
    day_t   out_day;
  } date_result_t;

  // limits for the watchdog on the whole run and for the final drain
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned DRAIN_CYCLES  = 2500;
  localparam int unsigned RANDOM_ITEMS  = 244;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic         in_tuser   = 1'b0;
  logic [63:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;

  date_result_t pending_results[$];
  int unsigned  mismatches    = 0;
  int unsigned  results_seen  = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  ready_hold    = 0;

  gregorian_date_add_and_diff_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic for the prediction
  // ---------------------------------------------------------------------------

  // days in month m of year y, 0 when m is not a month
  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m >= 1 && m <= 12) return 31;
    return 0;
  endfunction

  function automatic bit real_date(int unsigned d, int unsigned m, int unsigned y);
    if (m < 1 || m > 12 || y < 1 || y > gdad_pkg::MAX_YEAR) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // days from 01/01/0001 up to 01/01 of year y
  function automatic int unsigned days_to_year(int unsigned y);
    int unsigned p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  // serial day count, 01/01/0001 being day 0
  function automatic int unsigned day_number(int unsigned d, int unsigned m,
                                             int unsigned y);
    int unsigned n;
    n = days_to_year(y);
    for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
    return n + d - 1;
  endfunction

  // back from a serial day count to a calendar date
  function automatic void split_day_number(input int unsigned n, output int unsigned d,
                                           output int unsigned m, output int unsigned y);
    int unsigned rest;
    // estimate from the mean year length, then settle on the exact year
    y = int'((longint'(n) * 400) / 146097) + 1;
    while (days_to_year(y + 1) <= n) y++;
    while (y > 1 && days_to_year(y) > n) y--;
    rest = n - days_to_year(y);
    m = 1;
    while (m < 12 && rest >= month_days(m, y)) begin
      rest -= month_days(m, y);
      m++;
    end
    d = rest + 1;
  endfunction

  // expected result for one request
  function automatic date_result_t compute_date_result(gdad_pkg::action_t act,
                                                       date_fields_t f);
    date_result_t r;
    bit           earlier;
    int unsigned  sum, d, m, y;
    r = '0;
    // plain field compare, done even when b is not a date
    earlier = (f.year_a < f.year_b) ||
              (f.year_a == f.year_b && (f.month_a < f.month_b ||
               (f.month_a == f.month_b && f.day_a < f.day_b)));
    if (act == gdad_pkg::ACT_ADD) begin
      // an add checks and steps date a only
      if (!real_date(f.day_a, f.month_a, f.year_a)) begin
        r.bad_date = 1'b1;
      end else begin
        sum = day_number(f.day_a, f.month_a, f.year_a) + f.add_count;
        if (sum > day_number(gdad_pkg::LAST_DAY, gdad_pkg::DEC, gdad_pkg::MAX_YEAR)) begin
          // past the last representable day: clamp and flag
          r.out_day       = gdad_pkg::LAST_DAY;
          r.out_month     = gdad_pkg::DEC;
          r.out_year      = gdad_pkg::MAX_YEAR;
          r.year_overflow = 1'b1;
        end else begin
          split_day_number(sum, d, m, y);
          r.out_day   = day_t'(d);
          r.out_month = month_t'(m);
          r.out_year  = year_t'(y);
        end
        r.a_before_b = earlier;
      end
    end else begin
      if (!real_date(f.day_a, f.month_a, f.year_a) ||
          !real_date(f.day_b, f.month_b, f.year_b)) begin
        r.bad_date = 1'b1;
      end else begin
        r.a_before_b = earlier;
        if (earlier)
          r.day_distance = dist_t'(day_number(f.day_b, f.month_b, f.year_b) -
                                   day_number(f.day_a, f.month_a, f.year_a));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // results are checked before a new request is recorded; with one request in
  // flight a result can never belong to the request accepted at the same edge
  always @(posedge clk) begin : check_results
    date_result_t got;
    date_result_t want;
    string        wrong;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending: %h",
                                    results_seen, out_tdata));
        end else begin
          want  = pending_results.pop_front();
          wrong = "";
          if (got.out_day       !== want.out_day)       wrong = {wrong, " out_day"};
          if (got.out_month     !== want.out_month)     wrong = {wrong, " out_month"};
          if (got.out_year      !== want.out_year)      wrong = {wrong, " out_year"};
          if (got.a_before_b    !== want.a_before_b)    wrong = {wrong, " a_before_b"};
          if (got.day_distance  !== want.day_distance)  wrong = {wrong, " day_distance"};
          if (got.year_overflow !== want.year_overflow) wrong = {wrong, " year_overflow"};
          if (got.bad_date      !== want.bad_date)      wrong = {wrong, " bad_date"};
          if (wrong != "")
            report_mismatch($sformatf("result %0d wrong in%s: got %h want %h",
                                      results_seen, wrong, got, want));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(compute_date_result(gdad_pkg::action_t'(in_tuser),
                                                      date_fields_t'(in_tdata)));
    end
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: runs of ready and stall, mostly short, with an
  // occasional long stall and an occasional long stretch without any stall
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= !out_tready;
      if (out_tready) begin
        // about to stall
        ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(0, 3);
      end else begin
        ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(0, 10);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one request, after a random gap; valid stays high on return so that a
  // back-to-back request needs no drop
  task automatic send_request(input gdad_pkg::action_t act, input date_fields_t f);
    int unsigned gap;
    case ($urandom_range(0, 19))
      0:          gap = $urandom_range(20, 60);
      1, 2:       gap = $urandom_range(4, 10);
      3, 4, 5, 6: gap = $urandom_range(1, 3);
      default:    gap = 0;
    endcase
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic date_fields_t dates(int unsigned da, int unsigned ma, int unsigned ya,
                                         int unsigned db, int unsigned mb, int unsigned yb,
                                         int unsigned count);
    date_fields_t f;
    f           = '0;
    f.day_a     = day_t'(da);
    f.month_a   = month_t'(ma);
    f.year_a    = year_t'(ya);
    f.day_b     = day_t'(db);
    f.month_b   = month_t'(mb);
    f.year_b    = year_t'(yb);
    f.add_count = count_t'(count);
    return f;
  endfunction

  // mostly real dates, weighted towards the year range ends, century years and
  // month ends; now and then raw field bits
  task automatic pick_date(output day_t d, output month_t m, output year_t y);
    int unsigned len;
    if ($urandom_range(0, 99) < 12) begin
      d = day_t'($urandom);
      m = month_t'($urandom);
      y = year_t'($urandom);
    end else begin
      case ($urandom_range(0, 9))
        0:       y = year_t'($urandom_range(1, 4));
        1:       y = year_t'($urandom_range(9800, 9999));
        2:       y = year_t'(100 * $urandom_range(1, 99));
        3:       y = year_t'(4 * $urandom_range(1, 2499));
        default: y = year_t'($urandom_range(1, 9999));
      endcase
      m   = month_t'($urandom_range(1, 12));
      len = month_days(m, y);
      case ($urandom_range(0, 3))
        0:       d = day_t'(len);
        1:       d = day_t'(1);
        default: d = day_t'($urandom_range(1, len));
      endcase
    end
  endtask

  // adds across the whole range: start, end, clamping and the leap rules
  task automatic test_add_directed();
    send_request(gdad_pkg::ACT_ADD, dates(1, 1, 1, 1, 1, 1, 0));
    send_request(gdad_pkg::ACT_ADD, dates(1, 1, 1, 31, 12, 9999, 65535));
    send_request(gdad_pkg::ACT_ADD, dates(31, 12, 9999, 1, 1, 1, 0));
    send_request(gdad_pkg::ACT_ADD, dates(31, 12, 9999, 1, 1, 1, 1));   // one day too far
    send_request(gdad_pkg::ACT_ADD, dates(1, 1, 9999, 1, 1, 1, 65535)); // far past the end
    send_request(gdad_pkg::ACT_ADD, dates(28, 2, 1900, 1, 1, 1, 1));    // century, not leap
    send_request(gdad_pkg::ACT_ADD, dates(28, 2, 2000, 1, 1, 1, 1));    // fourth century, leap
    send_request(gdad_pkg::ACT_ADD, dates(31, 12, 2023, 1, 1, 2024, 1)); // year rollover
    // b is no date at all, yet the compare is still reported
    send_request(gdad_pkg::ACT_ADD, dates(29, 2, 2024, 31, 15, 16383, 366));
    send_request(gdad_pkg::ACT_ADD, dates(15, 6, 2010, 14, 6, 2010, 40000));
  endtask

  // distances: the longest one, equal dates, a after b and century februaries, leap or not
  task automatic test_distance_directed();
    send_request(gdad_pkg::ACT_DISTANCE, dates(1, 1, 1, 31, 12, 9999, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(31, 12, 9999, 1, 1, 1, 65535));
    send_request(gdad_pkg::ACT_DISTANCE, dates(5, 5, 2005, 5, 5, 2005, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(28, 2, 2100, 1, 3, 2100, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(29, 2, 1600, 1, 3, 1600, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(1, 1, 2000, 1, 1, 2001, 0));
  endtask

  // dates that do not exist, in the date that the request uses
  task automatic test_invalid_dates();
    send_request(gdad_pkg::ACT_ADD, dates(29, 2, 1900, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(0, 6, 2000, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(10, 0, 2000, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(10, 13, 2000, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(10, 6, 0, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(31, 4, 2000, 1, 1, 2000, 5));
    send_request(gdad_pkg::ACT_ADD, dates(31, 15, 16383, 31, 15, 16383, 65535));
    send_request(gdad_pkg::ACT_DISTANCE, dates(1, 1, 2000, 31, 15, 16383, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(29, 2, 2023, 1, 1, 2024, 0));
    send_request(gdad_pkg::ACT_DISTANCE, dates(1, 1, 2000, 1, 1, 0, 0));
  endtask

  // random mix of adds and distances; b is often pulled close to a so that
  // short distances and the compare on equal years and months get exercised
  task automatic test_random_requests();
    gdad_pkg::action_t act;
    date_fields_t      f;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      f   = '0;
      act = gdad_pkg::action_t'($urandom_range(0, 1));
      pick_date(f.day_a, f.month_a, f.year_a);
      pick_date(f.day_b, f.month_b, f.year_b);
      case ($urandom_range(0, 5))
        0: f.year_b = f.year_a;
        1: begin
          f.year_b  = f.year_a;
          f.month_b = f.month_a;
        end
        2: f.year_b = year_t'(f.year_a + $urandom_range(0, 8));
        3: {f.year_b, f.month_b, f.day_b} = {f.year_a, f.month_a, f.day_a};
        default: ;
      endcase
      case ($urandom_range(0, 5))
        0:       f.add_count = count_t'($urandom_range(0, 40));
        1:       f.add_count = count_t'($urandom_range(0, 800));
        2:       f.add_count = count_t'(16'hFFFF - $urandom_range(0, 100));
        default: f.add_count = count_t'($urandom);
      endcase
      send_request(act, f);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_add_directed();
    test_distance_directed();
    test_invalid_dates();
    test_random_requests();
    in_tvalid <= 1'b0;

    // let every outstanding result come back, then watch for strays
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/gdad_pkg.sv
src/gregorian_date_add_and_diff_core.sv
tb/testbench.sv
